/* hdl/assert_macros.svh */
// Assertion helpers used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/sha256h_pkg.sv */
package sha256h_pkg;

   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_MARK,
      SRC_ZERO,
      SRC_LEN
   } src_type;

   typedef struct packed {
      logic        push;
      src_type     src;
      logic        count;
      logic        round;
      logic [5:0]  round_idx;
      logic        add;
      logic        restart;
      logic [2:0]  word_idx;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
   } sts_type;

   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] LEN_START = 6'd56;
   localparam logic [7:0] PAD_MARK  = 8'h80;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      logic [63:0] d;
      d = {x, x} >> n;
      return d[31:0];
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

/* hdl/sha256h_if.sv */
interface sha256h_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface sha256h_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink (input valid, input digest_word, input word_index,
                 input last_word, output ready);
endinterface

/* hdl/sha256h_ctrl.sv */
`include "assert_macros.svh"

module sha256h_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_func,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sha256h_pkg::sts_type sts,
   output sha256h_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_ADD, S_EMIT} state_type;
   typedef enum logic [1:0] {P_NONE, P_MARK, P_ZERO, P_LEN} phase_type;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      round_in      = round_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      cmd           = '0;
      cmd.src       = sha256h_pkg::SRC_DATA;
      cmd.round_idx = round_ff;
      cmd.word_idx  = idx_ff;
      req_ready     = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!req_func) begin
                  cmd.push  = 1'b1;
                  cmd.count = 1'b1;
                  if (sts.fill == sha256h_pkg::FILL_LAST) begin
                     state_in = S_ROUND;
                  end
               end else begin
                  phase_in = P_MARK;
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            cmd.push = 1'b1;
            case (phase_ff)
               P_MARK: begin
                  cmd.src  = sha256h_pkg::SRC_MARK;
                  phase_in = P_ZERO;
               end
               P_ZERO: begin
                  // Zeros run until the length field's offset comes up.
                  if (sts.fill == sha256h_pkg::LEN_START) begin
                     cmd.src  = sha256h_pkg::SRC_LEN;
                     phase_in = P_LEN;
                  end else begin
                     cmd.src = sha256h_pkg::SRC_ZERO;
                  end
               end
               P_LEN: begin
                  cmd.src = sha256h_pkg::SRC_LEN;
               end
               default: begin
                  cmd.src = sha256h_pkg::SRC_ZERO;
               end
            endcase
            if (sts.fill == sha256h_pkg::FILL_LAST) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            round_in  = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.add = 1'b1;
            if (phase_ff == P_LEN) begin
               state_in = S_EMIT;
               valid_in = 1'b1;
               idx_in   = 3'd0;
            end else if (phase_ff != P_NONE) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.restart = 1'b1;
                  valid_in    = 1'b0;
                  phase_in    = P_NONE;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= P_NONE;
         round_ff <= 6'd0;
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   `ASSERT_NEXT(a_round_end, clock, reset, state_ff == S_ROUND && round_ff == 6'd63, state_ff == S_ADD)
   `ASSERT_NEXT(a_block_full, clock, reset, cmd.push && sts.fill == sha256h_pkg::FILL_LAST, state_ff == S_ROUND && round_ff == 6'd0)
   `ASSERT_NEXT(a_last_word, clock, reset, valid_ff && rsp_ready && idx_ff == 3'd7, !valid_ff && state_ff == S_IDLE)
   `ASSERT_IMPLIES(a_valid_emit, clock, reset, valid_ff, state_ff == S_EMIT)

endmodule

/* hdl/sha256h_dp.sv */
module sha256h_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           data_byte,
   input  sha256h_pkg::cmd_type cmd,
   output sha256h_pkg::sts_type sts,
   output logic [31:0]          digest_word
);

   logic [511:0] sched_ff, sched_in;
   logic [31:0]  v_ff [8];
   logic [31:0]  v_in [8];
   logic [31:0]  hash_ff [8];
   logic [31:0]  hash_in [8];
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  total_ff, total_in;

   logic [7:0]   push_byte;
   logic [63:0]  len_bits;
   logic [31:0]  w_cur, w_new, t1, t2, ch, maj;

   // Schedule window: word 0 of the window sits in the top 32 bits.
   assign w_cur = sched_ff[511:480];
   assign w_new = sha256h_pkg::small_sigma1(sched_ff[63:32]) + sched_ff[223:192]
                + sha256h_pkg::small_sigma0(sched_ff[479:448]) + w_cur;

   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + sha256h_pkg::big_sigma1(v_ff[4]) + ch
              + sha256h_pkg::ROUND_K[cmd.round_idx] + w_cur;
   assign t2  = sha256h_pkg::big_sigma0(v_ff[0]) + maj;

   assign len_bits = {total_ff[60:0], 3'b000};

   always_comb begin
      case (cmd.src)
         sha256h_pkg::SRC_DATA: push_byte = data_byte;
         sha256h_pkg::SRC_MARK: push_byte = sha256h_pkg::PAD_MARK;
         sha256h_pkg::SRC_LEN:  push_byte = 8'(len_bits >> {3'd7 - fill_ff[2:0], 3'b000});
         default:               push_byte = 8'h00;
      endcase
   end

   always_comb begin
      sched_in = sched_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      v_in     = v_ff;
      hash_in  = hash_ff;
      if (cmd.push) begin
         sched_in = {sched_ff[503:0], push_byte};
         fill_in  = fill_ff + 6'd1;
         if (fill_ff == sha256h_pkg::FILL_LAST) begin
            v_in = hash_ff;
         end
      end
      if (cmd.count) begin
         total_in = total_ff + 64'd1;
      end
      if (cmd.round) begin
         sched_in = {sched_ff[479:0], w_new};
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
      if (cmd.add) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + v_ff[i];
         end
      end
      if (cmd.restart) begin
         hash_in  = sha256h_pkg::INIT_HASH;
         fill_in  = 6'd0;
         total_in = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      v_ff     <= v_in;
      if (reset) begin
         hash_ff  <= sha256h_pkg::INIT_HASH;
         fill_ff  <= 6'd0;
         total_ff <= 64'd0;
      end else begin
         hash_ff  <= hash_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
      end
   end

   assign sts.fill    = fill_ff;
   assign digest_word = hash_ff[cmd.word_idx];

endmodule

/* hdl/sha256_byte_stream_hasher_unit.sv */
// Channel  Direction  Payload                               Transfer when
// req_bus  in         func, data_byte                       valid && ready
// rsp_bus  out        digest_word, word_index, last_word    valid && ready
//
// A data byte is taken while the unit is idle; every 64th byte then starts the 64 compression
// rounds, one per cycle in the shared round unit, and the final hash update.
// A finish item feeds one pad byte per cycle (9 to 72 bytes), runs one or two
// compressions, then offers eight digest words, one per transfer.
// Reset is synchronous and active high; it loads the initial hash values and
// clears the fill and byte counts. The input is held off while a block is
// compressed, padded or its digest is waiting; a stalled output simply holds.
module sha256_byte_stream_hasher_unit (
   input logic            clock,
   input logic            reset,
   sha256h_req_if.sink    req_bus,
   sha256h_rsp_if.source  rsp_bus
);

   sha256h_pkg::cmd_type cmd;
   sha256h_pkg::sts_type sts;

   // The controller sequences byte intake, padding, rounds and digest output.
   sha256h_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_func  (req_bus.func),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the block window, working variables and hash state.
   sha256h_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_bus.data_byte),
      .cmd         (cmd),
      .sts         (sts),
      .digest_word (rsp_bus.digest_word)
   );

   // Word position comes straight from the controller's output counter.
   assign rsp_bus.word_index = cmd.word_idx;
   assign rsp_bus.last_word  = (cmd.word_idx == 3'd7);

endmodule

/* dv/tb.sv */
module tb;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
   } hash_item_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   localparam logic FUNC_ABSORB = 1'b0;
   localparam logic FUNC_FINISH = 1'b1;

   logic clock;
   logic reset;

   sha256h_req_if req_bus ();
   sha256h_rsp_if rsp_bus ();

   sha256_byte_stream_hasher_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   // Predictor state: chaining value, partial block and message length.
   logic [31:0] chain_h [8];
   logic [7:0]  blk_buf [64];
   int unsigned blk_fill;
   logic [63:0] msg_bytes;

   hash_item_type   byte_queue [$];
   digest_beat_type digest_queue [$];

   int  fail_count;
   int  cycle_count;
   bit  stim_done;
   bit  quiet_phase;
   int  drv_gap;
   int  mon_stall;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Runs the 64 rounds over the buffered block and folds into chain_h.
   task automatic compress_buf();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = chain_h[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256h_pkg::ROUND_K[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
   endtask

   task automatic append_byte(input logic [7:0] b);
      blk_buf[blk_fill] = b;
      blk_fill++;
      if (blk_fill == 64) begin
         compress_buf();
         blk_fill = 0;
      end
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++) chain_h[i] = sha256h_pkg::INIT_HASH[i];
      blk_fill  = 0;
      msg_bytes = '0;
   endtask

   // Applies one accepted transfer; a finish pads, closes the message and
   // queues the eight digest words it must produce.
   task automatic predict_digest(input hash_item_type it);
      logic [63:0] bit_len;
      digest_beat_type beat;
      if (it.func == FUNC_ABSORB) begin
         append_byte(it.data_byte);
         msg_bytes++;
      end else begin
         bit_len = msg_bytes << 3;
         append_byte(sha256h_pkg::PAD_MARK);
         while (blk_fill != sha256h_pkg::LEN_START) append_byte(8'h00);
         for (int i = 0; i < 8; i++) append_byte(bit_len[63 - 8*i -: 8]);
         for (int i = 0; i < 8; i++) begin
            beat.digest_word = chain_h[i];
            beat.word_index  = i[2:0];
            beat.last_word   = (i == 7);
            digest_queue.push_back(beat);
         end
         restart_message();
      end
   endtask

   task automatic add_message(input int len, input bit ramp);
      hash_item_type it;
      for (int i = 0; i < len; i++) begin
         it.func      = FUNC_ABSORB;
         it.data_byte = ramp ? 8'(i) : 8'($urandom_range(0, 255));
         byte_queue.push_back(it);
      end
      it.func      = FUNC_FINISH;
      it.data_byte = 8'($urandom_range(0, 255));
      byte_queue.push_back(it);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver: one transfer per accepted handshake, random idle bursts until the
   // final quiet stretch.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.func      <= FUNC_ABSORB;
         req_bus.data_byte <= '0;
         drv_gap           <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_digest('{func: req_bus.func, data_byte: req_bus.data_byte});
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (drv_gap > 0) begin
               drv_gap       <= drv_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
               drv_gap       <= $urandom_range(0, 4);
               req_bus.valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               hash_item_type nxt;
               nxt = byte_queue.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.func      <= nxt.func;
               req_bus.data_byte <= nxt.data_byte;
            end else begin
               req_bus.valid <= 1'b0;
               stim_done     <= 1'b1;
            end
         end
      end
   end

   // Monitor: compares each result transfer with the oldest queued digest word.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         mon_stall     <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (digest_queue.size() == 0) begin
               $error("unexpected digest word %h", rsp_bus.digest_word);
               fail_count++;
            end else begin
               digest_beat_type exp_beat;
               exp_beat = digest_queue.pop_front();
               if (rsp_bus.digest_word !== exp_beat.digest_word) begin
                  $error("digest_word expected %h actual %h",
                         exp_beat.digest_word, rsp_bus.digest_word);
                  fail_count++;
               end
               if (rsp_bus.word_index !== exp_beat.word_index) begin
                  $error("word_index expected %0d actual %0d",
                         exp_beat.word_index, rsp_bus.word_index);
                  fail_count++;
               end
               if (rsp_bus.last_word !== exp_beat.last_word) begin
                  $error("last_word expected %0d actual %0d",
                         exp_beat.last_word, rsp_bus.last_word);
                  fail_count++;
               end
            end
         end
         if (mon_stall > 0) begin
            mon_stall     <= mon_stall - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            mon_stall     <= $urandom_range(0, 4);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.func      = FUNC_ABSORB;
      req_bus.data_byte = '0;
      rsp_bus.ready     = 1'b0;
      reset       = 1'b1;
      fail_count  = 0;
      cycle_count = 0;
      stim_done   = 1'b0;
      quiet_phase = 1'b0;
      restart_message();

      // Directed part: the empty message, a single byte, all-ones and
      // all-zeros bytes, and lengths that just fit or just spill the length
      // field (55 and 56 bytes) and exactly fill a block.
      add_message(0, 1'b0);
      byte_queue.push_back('{func: FUNC_ABSORB, data_byte: 8'hff});
      byte_queue.push_back('{func: FUNC_ABSORB, data_byte: 8'h00});
      byte_queue.push_back('{func: FUNC_FINISH, data_byte: 8'hff});
      add_message(1, 1'b0);
      add_message(55, 1'b1);
      add_message(56, 1'b0);
      add_message(64, 1'b0);
      // Random part: a few short messages of random bytes. The last messages
      // run with no idling at all.
      for (int m = 0; m < 5; m++) begin
         add_message($urandom_range(0, 12), 1'b0);
      end
      add_message(0, 1'b0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Quiet stretch for the last part of the run.
      wait (byte_queue.size() < 40 || cycle_count > CYCLE_LIMIT);
      quiet_phase = 1'b1;
      wait ((stim_done && !req_bus.valid && digest_queue.size() == 0)
            || cycle_count > CYCLE_LIMIT);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         repeat (200) @(posedge clock);
         if (fail_count == 0 && digest_queue.size() == 0)
            $display("All tests passed");
         else
            $display("Some tests failed");
         $finish;
      end
   end
endmodule
